[hw/rtl/moving_average_deviation_ring_assert.svh]
// ----------------------------------------------------------------------------
// moving average deviation ring: assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_DEVIATION_RING_ASSERT_SVH
`define MOVING_AVERAGE_DEVIATION_RING_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked on every edge outside reset
`define MADR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define MADR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MADR_ASSERT(lbl, prop, msg)
`define MADR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/madr_pkg.sv]
// ----------------------------------------------------------------------------
// madr_pkg
// shared widths, limits and divider handshake types of the deviation ring
// ----------------------------------------------------------------------------
package madr_pkg;

  // store depth and field widths
  localparam int MaxWindow = 128;
  localparam int SampleW   = 32;
  localparam int IdxW      = $clog2(MaxWindow);
  localparam int DivisorW  = IdxW + 1;
  localparam int TotalW    = SampleW + IdxW + 1;
  localparam int DevW      = SampleW + 1;
  localparam int CntW      = $clog2(TotalW + 1);

  // configuration port
  localparam int CfgW  = 8;
  localparam int DataW = 32;
  localparam int AddrW = 3;
  localparam logic [CfgW-1:0] WindowReset = 8'd20;

  // saturation limits on the quotient magnitude
  localparam logic [TotalW-1:0] PosLimit = TotalW'((64'd1 << (SampleW - 1)) - 64'd1);
  localparam logic [TotalW-1:0] NegLimit = TotalW'(64'd1 << (SampleW - 1));
  localparam logic [SampleW-1:0] AvgMax = {1'b0, {(SampleW - 1){1'b1}}};
  localparam logic [SampleW-1:0] AvgMin = {1'b1, {(SampleW - 1){1'b0}}};

  // divider request and response
  typedef struct packed {
    logic                start;
    logic [TotalW-1:0]   dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TotalW-1:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/madr_in_if.sv]
// ----------------------------------------------------------------------------
// madr_in_if
// input channel: command and sample word with valid/ready
// ----------------------------------------------------------------------------
interface madr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [madr_pkg::SampleW-1:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink   (input valid, command, sample, output ready);
endinterface

[hw/rtl/madr_out_if.sv]
// ----------------------------------------------------------------------------
// madr_out_if
// result channel: deviation, average and fill flag with valid/ready
// ----------------------------------------------------------------------------
interface madr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [madr_pkg::DevW-1:0]    deviation;
  logic signed [madr_pkg::SampleW-1:0] average;
  logic                                window_full;

  modport source (output valid, deviation, average, window_full, input ready);
  modport sink   (input valid, deviation, average, window_full, output ready);
endinterface

[hw/rtl/madr_div.sv]
// ----------------------------------------------------------------------------
// madr_div
// restoring serial divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module madr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  madr_pkg::div_req_t  req_i,
  output madr_pkg::div_rsp_t  rsp_o
);
  import madr_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [TotalW-1:0]   quo_q;
  logic [IdxW-1:0]     rem_q;
  logic [DivisorW-1:0] divisor_q;
  logic [DivisorW-1:0] trial;
  logic [DivisorW-1:0] diff;
  logic                ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, quo_q[TotalW-1]};
    ge    = (trial >= divisor_q);
    diff  = trial - divisor_q;
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(TotalW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[TotalW-2:0], ge};
      rem_q <= ge ? diff[IdxW-1:0] : trial[IdxW-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[hw/rtl/moving_average_deviation_ring.sv]
// ----------------------------------------------------------------------------
// moving_average_deviation_ring
// running-sum moving average over a ring store, reports sample minus average
// ----------------------------------------------------------------------------
// in_if carries one word per item: command 0 pushes a signed Q16.16 sample,
// command 1 clears the store, the total, the write index and the fill flag.
// out_if returns one word per item: deviation, average and window_full
// (all zero for a clear).
// A push runs through StUpd, which updates the store and total, StLoad,
// which loads the divider, StDiv, where the serial divider takes 40 steps
// (one quotient bit per step over the 40-bit total) up to its done flag, and
// StFin, which registers the result. A clear goes straight to StFin.
// in_if.ready is high only while no item is in progress, so a push is not
// taken before the previous item has left StFin; a new item may be accepted
// while the previous result still waits in the output register.
// A stalled receiver holds the finished result in the datapath until the
// output register frees, and no further item is accepted meanwhile.
// Reset empties the store at once (per-entry valid bits), zeroes the total,
// index and flag, and sets window_length to 20.
// The APB-style port holds window_length at byte address 0; pready is
// always high and a write lands on the access cycle.
// ----------------------------------------------------------------------------
`include "moving_average_deviation_ring_assert.svh"

module moving_average_deviation_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  madr_in_if.sink                      in_if,
  madr_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [madr_pkg::AddrW-1:0]   paddr,
  input  logic [madr_pkg::DataW-1:0]   pwdata,
  output logic [madr_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import madr_pkg::*;

  localparam logic RegWindowLength = 1'b0;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StUpd  = 5'b00010,
    StLoad = 5'b00100,
    StDiv  = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  logic [CfgW-1:0]            win_q;
  logic                       cfg_we;
  logic                       in_fire;
  logic                       clr_q;
  logic signed [SampleW-1:0]  smp_q;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic                       filled_q, filled_d;
  logic signed [TotalW-1:0]   total_q, total_d;
  logic                       neg_q;
  logic [DivisorW-1:0]        div_q, divisor_d;
  logic [DivisorW-1:0]        win_eff;
  logic [DivisorW-1:0]        next_idx;
  logic [MaxWindow-1:0]       vld_q;
  logic [SampleW-1:0]         store_q [MaxWindow];
  logic signed [SampleW-1:0]  rd_data_q;
  logic                       rd_vld_q;
  logic signed [SampleW-1:0]  old_smp;
  logic                       out_load;
  logic                       out_vld_q;
  logic signed [DevW-1:0]     dev_q, dev_d;
  logic signed [SampleW-1:0]  avg_q, avg_d;
  logic                       full_q;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  // configuration port
  assign cfg_we = psel && penable && pwrite && (paddr[AddrW-1] == RegWindowLength);
  assign prdata = (paddr[AddrW-1] == RegWindowLength) ? DataW'(win_q) : '0;
  assign pready = 1'b1;

  // handshakes
  assign in_fire     = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == StIdle);
  assign out_load    = (state_q == StFin) && (!out_vld_q || out_if.ready);

  // effective window, zero reads as one, clipped to depth
  always_comb begin
    if (win_q == '0) begin
      win_eff = DivisorW'(1);
    end else if (32'(win_q) > MaxWindow) begin
      win_eff = DivisorW'(MaxWindow);
    end else begin
      win_eff = DivisorW'(win_q);
    end
  end

  // ring update: drop the old entry, add the new sample, advance the index
  always_comb begin
    old_smp   = rd_vld_q ? rd_data_q : '0;
    total_d   = total_q - TotalW'(old_smp) + TotalW'(smp_q);
    next_idx  = {1'b0, idx_q} + DivisorW'(1);
    divisor_d = filled_q ? win_eff : next_idx;
    filled_d  = filled_q;
    idx_d     = next_idx[IdxW-1:0];
    if (next_idx >= win_eff) begin
      idx_d    = '0;
      filled_d = 1'b1;
    end
  end

  // saturate the signed quotient, then form the deviation
  always_comb begin
    if (clr_q) begin
      avg_d = '0;
    end else if (!neg_q) begin
      avg_d = (div_rsp.quotient > PosLimit) ? AvgMax : div_rsp.quotient[SampleW-1:0];
    end else begin
      avg_d = (div_rsp.quotient > NegLimit) ? AvgMin : -div_rsp.quotient[SampleW-1:0];
    end
    dev_d = clr_q ? '0 : (DevW'(smp_q) - DevW'(avg_d));
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = in_if.command ? StFin : StUpd;
        end
      end
      StUpd:  state_d = StLoad;
      StLoad: state_d = StDiv;
      StDiv: begin
        if (div_rsp.done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      win_q     <= WindowReset;
      idx_q     <= '0;
      filled_q  <= 1'b0;
      total_q   <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        win_q <= pwdata[CfgW-1:0];
      end
      if (in_fire && in_if.command) begin
        vld_q    <= '0;
        total_q  <= '0;
        idx_q    <= '0;
        filled_q <= 1'b0;
      end
      if (state_q == StUpd) begin
        vld_q[idx_q] <= 1'b1;
        total_q      <= total_d;
        idx_q        <= idx_d;
        filled_q     <= filled_d;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q <= in_if.sample;
      clr_q <= in_if.command;
    end
    if (state_q == StUpd) begin
      div_q <= divisor_d;
    end
    if (state_q == StLoad) begin
      neg_q <= total_q[TotalW-1];
    end
    if (out_load) begin
      dev_q  <= dev_d;
      avg_q  <= avg_d;
      full_q <= clr_q ? 1'b0 : filled_q;
    end
  end

  // sample store, registered read at the write index
  always_ff @(posedge clk_i) begin
    if (state_q == StUpd) begin
      store_q[idx_q] <= smp_q;
    end
    rd_data_q <= store_q[idx_q];
    rd_vld_q  <= vld_q[idx_q];
  end

  // divider on the magnitude of the total
  assign div_req.start    = (state_q == StLoad);
  assign div_req.dividend = total_q[TotalW-1] ? -total_q : total_q;
  assign div_req.divisor  = div_q;

  madr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // result channel
  assign out_if.valid       = out_vld_q;
  assign out_if.deviation   = dev_q;
  assign out_if.average     = avg_q;
  assign out_if.window_full = full_q;

  // checks
  `MADR_ASSERT(a_done_in_div, div_rsp.done |-> (state_q == StDiv), "divider done outside divide")
  `MADR_ASSERT(a_clear_empties,
               (in_fire && in_if.command) |=> (total_q == '0 && !filled_q && idx_q == '0),
               "clear left state behind")
  `MADR_ASSERT_ALWAYS(a_divisor_nonzero, (state_q == StDiv) |-> (div_q != '0), "zero divisor")

endmodule

[verif/madr_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// madr_tb_pkg
// command codes and register addresses shared by the deviation ring bench
// ----------------------------------------------------------------------------
package madr_tb_pkg;

  // input word commands
  localparam logic CmdPush  = 1'b0;
  localparam logic CmdClear = 1'b1;

  // register map
  localparam logic [madr_pkg::AddrW-1:0] WindowAddr = '0;

endpackage

[verif/madr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// madr_checker
// predicts every result word of the deviation ring and compares it
// ----------------------------------------------------------------------------
// Watches the input and result channels and the register port. Each accepted
// input word runs through a local copy of the ring store, the running total,
// the write index and the fill flag; the predicted word is queued and
// compared field by field with the next accepted result word. Register reads
// are compared with the tracked window length.
// ----------------------------------------------------------------------------
module madr_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  madr_in_if                           in_mon,
  madr_out_if                          out_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [madr_pkg::AddrW-1:0]   paddr,
  input  logic [madr_pkg::DataW-1:0]   pwdata,
  input  logic [madr_pkg::DataW-1:0]   prdata,
  input  logic                         pready,
  output int                           mismatches_o,
  output int                           outstanding_o,
  output int                           words_checked_o,
  output int                           clears_seen_o,
  output int                           saturations_o
);
  import madr_pkg::*;
  import madr_tb_pkg::*;

  typedef struct {
    logic signed [DevW-1:0]    deviation;
    logic signed [SampleW-1:0] average;
    logic                      window_full;
  } dev_word_t;

  // local copy of the block state
  logic signed [SampleW-1:0] ring_store [MaxWindow];
  logic signed [TotalW-1:0]  ring_total;
  int unsigned               ring_idx;
  logic                      ring_full;
  logic [CfgW-1:0]           window_len;

  dev_word_t expected_words [$];
  dev_word_t exp_w;
  dev_word_t pred_w;
  int        mismatch_cnt;
  int        checked_cnt;
  int        clear_cnt;
  int        sat_cnt;

  task automatic empty_ring();
    for (int i = 0; i < MaxWindow; i++) ring_store[i] = '0;
    ring_total = '0;
    ring_idx   = 0;
    ring_full  = 1'b0;
  endtask

  // one input word through the ring: update state, return the result word
  task automatic ring_step(input logic cmd, input logic signed [SampleW-1:0] smp,
                           output dev_word_t w);
    int unsigned eff;
    int unsigned nxt;
    int unsigned divisor;
    longint      quot;
    if (cmd == CmdClear) begin
      empty_ring();
      w.deviation   = '0;
      w.average     = '0;
      w.window_full = 1'b0;
      clear_cnt++;
    end else begin
      // zero acts as one, anything past the store depth saturates
      eff = (window_len == 0) ? 1 : int'(window_len);
      if (eff > MaxWindow) eff = MaxWindow;
      ring_total = ring_total - ring_store[ring_idx] + smp;
      ring_store[ring_idx] = smp;
      nxt = ring_idx + 1;
      divisor = ring_full ? eff : nxt;
      // wrap also covers an index left above a shrunken window
      if (nxt >= eff) begin
        nxt = 0;
        ring_full = 1'b1;
      end
      ring_idx = nxt;
      quot = longint'(ring_total) / longint'(divisor);
      // stale entries can push the average out of the 32-bit range
      if (quot > 64'sd2147483647) begin
        quot = 64'sd2147483647;
        sat_cnt++;
      end else if (quot < -64'sd2147483648) begin
        quot = -64'sd2147483648;
        sat_cnt++;
      end
      w.average     = quot[SampleW-1:0];
      w.deviation   = DevW'(longint'(smp) - quot);
      w.window_full = ring_full;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_ring();
      window_len = WindowReset;
      expected_words.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
      clear_cnt    = 0;
      sat_cnt      = 0;
    end else begin
      // window register writes and reads
      if (psel && penable && pready && paddr == WindowAddr) begin
        if (pwrite) begin
          window_len = pwdata[CfgW-1:0];
        end else if (prdata[CfgW-1:0] !== window_len) begin
          $error("window_length: expected %0d, got %0d", window_len, prdata[CfgW-1:0]);
          mismatch_cnt++;
        end
      end
      // result words against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no input word waiting");
          mismatch_cnt++;
        end else begin
          exp_w = expected_words.pop_front();
          checked_cnt++;
          if (out_mon.deviation !== exp_w.deviation) begin
            $error("deviation: expected %0d, got %0d", exp_w.deviation, out_mon.deviation);
            mismatch_cnt++;
          end
          if (out_mon.average !== exp_w.average) begin
            $error("average: expected %0d, got %0d", exp_w.average, out_mon.average);
            mismatch_cnt++;
          end
          if (out_mon.window_full !== exp_w.window_full) begin
            $error("window_full: expected %0d, got %0d",
                   exp_w.window_full, out_mon.window_full);
            mismatch_cnt++;
          end
        end
      end
      // accepted input words
      if (in_mon.valid && in_mon.ready) begin
        ring_step(in_mon.command, in_mon.sample, pred_w);
        expected_words.push_back(pred_w);
      end
    end
    mismatches_o    <= mismatch_cnt;
    outstanding_o   <= expected_words.size();
    words_checked_o <= checked_cnt;
    clears_seen_o   <= clear_cnt;
    saturations_o   <= sat_cnt;
  end

endmodule

[verif/tb_moving_average_deviation_ring.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_moving_average_deviation_ring
// stimulus and verdict for the moving average deviation ring
// ----------------------------------------------------------------------------
// A directed part hits the sample extremes, clears, window lengths of zero,
// one and above the store depth, and a window shrunk over stale entries so
// that the average saturates. Random segments follow under a range of window
// lengths with random gaps on the sender and random stalls on the receiver.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_moving_average_deviation_ring;
  import madr_pkg::*;
  import madr_tb_pkg::*;

  localparam int CycleLimit  = 800_000;
  localparam int SegWords    = 180;
  localparam int PauseEvery  = 97;
  localparam int SettleCycles = 60;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int mismatches;
  int outstanding;
  int words_checked;
  int clears_seen;
  int saturations;
  int cycle_count = 0;
  int window_settings = 0;
  int stall_left;
  bit no_idle = 1'b0;

  madr_in_if  in_if ();
  madr_out_if out_if ();

  moving_average_deviation_ring dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  madr_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding),
    .words_checked_o (words_checked),
    .clears_seen_o   (clears_seen),
    .saturations_o   (saturations)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall after each accepted result word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_if.valid && out_if.ready) begin
      if (no_idle) begin
        stall_left <= 0;
      end else begin
        stall_left <= $urandom_range(0, 7);
      end
      out_if.ready <= no_idle || (stall_left == 0 && $urandom_range(0, 7) == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left   <= 0;
      out_if.ready <= 1'b1;
    end
  end

  // random sample, weighted toward extremes and small values
  function automatic logic [SampleW-1:0] draw_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: draw_sample = AvgMax;
      1: draw_sample = AvgMin;
      2: draw_sample = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      3: draw_sample = $urandom_range(0, 2) - 1;
      default: draw_sample = $urandom();
    endcase
  endfunction

  // one input word with a random gap ahead of it
  task automatic send_word(input logic cmd, input logic [SampleW-1:0] smp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.sample  <= smp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // stop sending and wait for every result word
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // setup and access cycle, then the bus is left idle
  task automatic reg_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // new window length while idle, read back afterwards
  task automatic set_window(input logic [CfgW-1:0] w);
    drain();
    reg_access(1'b1, WindowAddr, {DataW'($urandom()) & ~DataW'(8'hFF)} | DataW'(w));
    reg_access(1'b0, WindowAddr, '0);
    window_settings++;
  endtask

  task automatic random_segment(input logic [CfgW-1:0] w, input bit calm);
    logic cmd;
    set_window(w);
    no_idle = calm;
    for (int i = 0; i < SegWords; i++) begin
      // sender holds off until the block has drained
      if (i != 0 && i % PauseEvery == 0) drain();
      cmd = ($urandom_range(0, 149) == 0) ? CmdClear : CmdPush;
      send_word(cmd, draw_sample());
    end
    no_idle = 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.command <= CmdPush;
    in_if.sample  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window, extremes and a clear
    reg_access(1'b0, WindowAddr, '0);
    send_word(CmdPush, AvgMax);
    send_word(CmdPush, AvgMin);
    send_word(CmdPush, '1);
    send_word(CmdClear, $urandom());
    send_word(CmdPush, '0);

    // short window that wraps
    set_window(8'd3);
    repeat (3) send_word(CmdPush, AvgMax);
    send_word(CmdPush, AvgMin);

    // zero length acts as one
    set_window(8'd0);
    send_word(CmdPush, AvgMin);
    send_word(CmdPush, AvgMax);

    // length above depth, then shrunk over stale maxima
    set_window(8'd255);
    send_word(CmdClear, '0);
    repeat (4) send_word(CmdPush, AvgMax);
    set_window(8'd1);
    repeat (2) send_word(CmdPush, AvgMax);

    // full depth, then shrunk over stale minima
    set_window(8'd128);
    send_word(CmdClear, '0);
    repeat (4) send_word(CmdPush, AvgMin);
    set_window(8'd1);
    repeat (2) send_word(CmdPush, AvgMin);

    // random segments across window lengths
    random_segment(8'd1, 1'b0);
    random_segment(8'd128, 1'b0);
    random_segment(8'd0, 1'b1);
    random_segment(8'd255, 1'b0);
    random_segment(8'd2, 1'b0);
    random_segment(8'd129, 1'b0);
    random_segment(8'd20, 1'b1);
    random_segment(8'($urandom_range(3, 127)), 1'b0);
    random_segment(8'($urandom_range(1, 128)), 1'b0);
    random_segment(8'($urandom_range(0, 255)), 1'b0);

    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d window settings, %0d result words checked, %0d clears",
             window_settings, words_checked, clears_seen);
    $display("%0d averages saturated from stale entries", saturations);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
